@@ hw/rtl/kti_pkg.sv @@
package kti_pkg;

	localparam int MaxKeysDefault = 16;
	localparam int ValW = 32;

	localparam logic [1:0] KIND_APPEND = 2'd0;
	localparam logic [1:0] KIND_CLEAR  = 2'd1;
	localparam logic [1:0] KIND_QUERY  = 2'd2;

	localparam logic [1:0] ST_INTERP = 2'd0;
	localparam logic [1:0] ST_SINGLE = 2'd1;
	localparam logic [1:0] ST_CLAMP  = 2'd2;
	localparam logic [1:0] ST_EMPTY  = 2'd3;

	typedef struct packed {
		logic [1:0]  kind;
		logic [31:0] key_time;
		logic [31:0] key_x;
		logic [31:0] key_y;
		logic [31:0] key_z;
		logic [31:0] query_time;
	} req_t;

	typedef struct packed {
		logic [31:0] out_x;
		logic [31:0] out_y;
		logic [31:0] out_z;
		logic [1:0]  status;
	} rsp_t;

	// one key as stored: time, x, y, z
	typedef struct packed {
		logic [31:0] t;
		logic [31:0] x;
		logic [31:0] y;
		logic [31:0] z;
	} key_t;

	// divider handshake
	typedef struct packed {
		logic        start;
		logic [31:0] num;
		logic [31:0] den;
	} div_req_t;

	typedef struct packed {
		logic        done;
		logic [15:0] quo;
	} div_rsp_t;

endpackage

@@ hw/rtl/kti_if.sv @@
interface kti_req_if;
	logic            valid;
	logic            ready;
	kti_pkg::req_t   payload;
	modport source(output valid, output payload, input ready);
	modport sink(input valid, input payload, output ready);
endinterface

interface kti_rsp_if;
	logic            valid;
	logic            ready;
	kti_pkg::rsp_t   payload;
	modport source(output valid, output payload, input ready);
	modport sink(input valid, input payload, output ready);
endinterface

@@ hw/rtl/kti_key_mem.sv @@
// Key storage: one write port, one registered read port.
module kti_key_mem #(
	parameter int MaxKeys = kti_pkg::MaxKeysDefault,
	localparam int AW = (MaxKeys > 1) ? $clog2(MaxKeys) : 1
) (
	input  logic              clk,
	input  logic              we,
	input  logic [AW-1:0]     waddr,
	input  kti_pkg::key_t     wdata,
	input  logic [AW-1:0]     raddr,
	output kti_pkg::key_t     rdata
);
	kti_pkg::key_t mem [MaxKeys];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end
endmodule

@@ hw/rtl/kti_divider.sv @@
// Restoring divider: quotient of (num << 16) / den, 16 bits, one bit per cycle.
// Caller guarantees num < den so the quotient fits.
module kti_divider (
	input  logic               clk,
	input  logic               arst_n,
	input  kti_pkg::div_req_t  req,
	output kti_pkg::div_rsp_t  rsp
);
	logic [32:0] rem_q;
	logic [31:0] den_q;
	logic [15:0] quo_q;
	logic [4:0]  cnt_q;
	logic        busy_q;
	logic        done_q;
	logic [33:0] shifted;
	logic [33:0] diff;

	assign shifted = {rem_q, 1'b0};
	assign diff = shifted - {2'b00, den_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (req.start) begin
				busy_q <= 1'b1;
				cnt_q  <= 5'd16;
			end else if (busy_q) begin
				cnt_q <= cnt_q - 5'd1;
				if (cnt_q == 5'd1) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req.start) begin
			rem_q <= {1'b0, req.num};
			den_q <= req.den;
			quo_q <= '0;
		end else if (busy_q) begin
			if (!diff[33]) begin
				rem_q <= diff[32:0];
				quo_q <= {quo_q[14:0], 1'b1};
			end else begin
				rem_q <= shifted[32:0];
				quo_q <= {quo_q[14:0], 1'b0};
			end
		end
	end

	assign rsp.done = done_q;
	assign rsp.quo  = quo_q;
endmodule

@@ hw/rtl/keyframe_track_interpolator_unit.sv @@
// Keyframe track interpolator. Keeps up to MaxKeys keys (time, x, y, z) in a
// synchronous memory. Append and clear complete in the cycle they are taken. A
// query reads the keys one at a time, each through a read and a check state,
// until a key time exceeds the query time or the last key is reached. On a
// later key it runs three sequential 33x17 multiplies, preceded by a 16-step
// bit-serial divide for the factor unless the query time lies before the
// earlier key. One request is worked at a time; a finished result waits in an
// output register and holds off new requests until it is taken.
module keyframe_track_interpolator_unit #(
	parameter int MaxKeys = kti_pkg::MaxKeysDefault
) (
	input  logic      clk,
	input  logic      arst_n,
	kti_req_if.sink   req,
	kti_rsp_if.source rsp
);
	localparam int AW = (MaxKeys > 1) ? $clog2(MaxKeys) : 1;
	localparam int CW = $clog2(MaxKeys + 1);

	localparam logic [3:0] S_IDLE  = 4'd0;
	localparam logic [3:0] S_RD    = 4'd1;
	localparam logic [3:0] S_CHK   = 4'd2;
	localparam logic [3:0] S_DIV   = 4'd3;
	localparam logic [3:0] S_MUL   = 4'd4;
	localparam logic [3:0] S_OUT   = 4'd5;
	localparam logic [3:0] S_RD0   = 4'd6;
	localparam logic [3:0] S_PRE   = 4'd7;

	logic [3:0]    state_q;
	logic [CW-1:0] count_q;
	logic [CW-1:0] idx_q;
	logic [31:0]   qt_q;
	kti_pkg::key_t k0_q, k1_q;
	logic [15:0]   fac_q;
	logic [1:0]    comp_q;
	logic [31:0]   rx_q, ry_q, rz_q;
	logic [1:0]    st_q;
	logic          ov_q;
	kti_pkg::rsp_t opay_q;

	logic              we;
	logic [AW-1:0]     waddr, raddr;
	kti_pkg::key_t     wdata, rdata;
	kti_pkg::div_req_t dreq;
	kti_pkg::div_rsp_t drsp;

	logic acc;
	assign req.ready = (state_q == S_IDLE) && !(ov_q && !rsp.ready);
	assign acc = req.valid && req.ready;

	assign we    = acc && (req.payload.kind == kti_pkg::KIND_APPEND)
	               && (count_q < CW'(MaxKeys));
	assign waddr = count_q[AW-1:0];
	assign wdata = '{t: req.payload.key_time, x: req.payload.key_x,
	                 y: req.payload.key_y, z: req.payload.key_z};
	assign raddr = idx_q[AW-1:0];

	kti_key_mem #(.MaxKeys(MaxKeys)) u_mem (
		.clk(clk), .we(we), .waddr(waddr), .wdata(wdata),
		.raddr(raddr), .rdata(rdata)
	);

	// divider operands from the found pair
	assign dreq.start = (state_q == S_CHK) && (qt_q < rdata.t) && (qt_q >= k0_q.t);
	assign dreq.num   = qt_q - k0_q.t;
	assign dreq.den   = rdata.t - k0_q.t;

	kti_divider u_div (.clk(clk), .arst_n(arst_n), .req(dreq), .rsp(drsp));

	// one shared multiplier: component selected by comp_q
	logic signed [32:0] s_cur, e_cur, delta;
	logic signed [50:0] prod;
	logic signed [34:0] sum;
	always_comb begin
		case (comp_q)
			2'd0:    begin s_cur = 33'(signed'(k0_q.x)); e_cur = 33'(signed'(k1_q.x)); end
			2'd1:    begin s_cur = 33'(signed'(k0_q.y)); e_cur = 33'(signed'(k1_q.y)); end
			default: begin s_cur = 33'(signed'(k0_q.z)); e_cur = 33'(signed'(k1_q.z)); end
		endcase
		delta = e_cur - s_cur;
		prod  = 51'(delta) * signed'({35'd0, fac_q});
		sum   = 35'(s_cur) + 35'(prod >>> 16);
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ov_q <= 1'b0;
		end else if (state_q == S_OUT) begin
			ov_q <= 1'b1;
		end else if (rsp.ready) begin
			ov_q <= 1'b0;
		end
	end
	always_ff @(posedge clk) begin
		if (state_q == S_OUT) begin
			opay_q <= '{out_x: rx_q, out_y: ry_q, out_z: rz_q, status: st_q};
		end
	end
	assign rsp.valid   = ov_q;
	assign rsp.payload = opay_q;

	// control sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			count_q <= '0;
			idx_q   <= '0;
			comp_q  <= '0;
		end else begin
			unique case (state_q)
				S_IDLE: begin
					if (acc) begin
						unique case (req.payload.kind)
							kti_pkg::KIND_APPEND: begin
								if (we) count_q <= count_q + CW'(1);
							end
							kti_pkg::KIND_CLEAR: count_q <= '0;
							kti_pkg::KIND_QUERY: begin
								idx_q <= '0;
								if (count_q == '0) state_q <= S_OUT;
								else state_q <= S_RD0;
							end
							default: ;
						endcase
					end
				end
				S_RD0: state_q <= S_PRE;
				S_PRE: begin
					if (count_q == CW'(1)) state_q <= S_OUT;
					else begin
						idx_q   <= CW'(1);
						state_q <= S_RD;
					end
				end
				S_RD: state_q <= S_CHK;
				S_CHK: begin
					if (qt_q < rdata.t) begin
						comp_q  <= '0;
						state_q <= (qt_q >= k0_q.t) ? S_DIV : S_MUL;
					end else if (idx_q == count_q - CW'(1)) begin
						state_q <= S_OUT;
					end else begin
						idx_q   <= idx_q + CW'(1);
						state_q <= S_RD;
					end
				end
				S_DIV: if (drsp.done) state_q <= S_MUL;
				S_MUL: begin
					comp_q <= comp_q + 2'd1;
					if (comp_q == 2'd2) state_q <= S_OUT;
				end
				S_OUT: state_q <= S_IDLE;
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// datapath registers
	always_ff @(posedge clk) begin
		case (state_q)
			S_IDLE: begin
				qt_q <= req.payload.query_time;
				rx_q <= '0; ry_q <= '0; rz_q <= '0;
				st_q <= kti_pkg::ST_EMPTY;
			end
			S_PRE: begin
				k0_q <= rdata;
				rx_q <= rdata.x; ry_q <= rdata.y; rz_q <= rdata.z;
				st_q <= kti_pkg::ST_SINGLE;
			end
			S_CHK: begin
				k1_q <= rdata;
				fac_q <= '0;
				if (qt_q < rdata.t) begin
					st_q <= kti_pkg::ST_INTERP;
				end else begin
					k0_q <= rdata;
					rx_q <= rdata.x; ry_q <= rdata.y; rz_q <= rdata.z;
					st_q <= kti_pkg::ST_CLAMP;
				end
			end
			S_DIV: if (drsp.done) fac_q <= drsp.quo;
			S_MUL: begin
				case (comp_q)
					2'd0:    rx_q <= sum[31:0];
					2'd1:    ry_q <= sum[31:0];
					default: rz_q <= sum[31:0];
				endcase
			end
			default: ;
		endcase
	end
endmodule

@@ hw/rtl/kti_checker.sv @@
module kti_checker (
	input logic          clk,
	input logic          arst_n,
	input logic          in_valid,
	input logic          in_ready,
	input logic          out_valid,
	input logic          out_ready,
	input kti_pkg::rsp_t out_payload
);
	// a held result stays until taken
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(out_payload))
		else $error("result dropped or changed while stalled");

	// empty-track status carries zero values
	a_empty: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_payload.status == kti_pkg::ST_EMPTY |->
		out_payload.out_x == '0 && out_payload.out_y == '0 && out_payload.out_z == '0)
		else $error("empty track with nonzero values");

	// no request is taken while a stalled result blocks
	a_block: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |-> !in_ready)
		else $error("request taken under a stalled result");
endmodule

bind keyframe_track_interpolator_unit kti_checker u_chk (
	.clk(clk), .arst_n(arst_n),
	.in_valid(req.valid), .in_ready(req.ready),
	.out_valid(rsp.valid), .out_ready(rsp.ready),
	.out_payload(rsp.payload)
);
